### hdl/ggsc_pkg.sv
// Shared types, widths and constants of the go-to-goal speed controller.
// Used by every module of the block; depends on nothing.
package ggsc_pkg;

   // Number of CORDIC micro-rotation stages (8 to 24).
   localparam int CORDIC_ITERATIONS = 16;

   localparam int PW     = 16;           // pose and target coordinates
   localparam int HW     = 15;           // heading
   localparam int DW     = PW + 1;       // goal minus pose
   localparam int PRE_SH = 8;            // Q5.10 to Q5.18 scaling
   localparam int XW     = DW + PRE_SH + 3; // CORDIC x/y, room for gain and sign
   localparam int ZW     = 17;           // angle accumulator, Q3.12
   localparam int EW     = ZW + 1;       // heading error
   localparam int GW     = 12;           // speed gain
   localparam int SW     = 15;           // speeds and tolerances
   localparam int INVW   = 16;           // 1/K in Q0.16
   localparam int PRODW  = XW - 1 + INVW;
   localparam int DIST_SHIFT = 24;
   localparam int DISTW  = PRODW - DIST_SHIFT;
   localparam int LINW   = GW + DISTW;
   localparam int GAIN_SHIFT = 8;

   localparam logic [INVW-1:0]        INV_GAIN_Q16 = INVW'(39797);
   localparam logic [PRODW-1:0]       DIST_ROUND   = PRODW'(1) << (DIST_SHIFT - 1);
   localparam logic signed [ZW-1:0]   PI_Q12       = ZW'(12868);
   localparam logic [EW-1:0]          ANG_MAX      = EW'(32767);

   localparam int CSR_IW = 3;
   localparam int CSR_DW = 16;

   typedef enum logic [CSR_IW-1:0] {
      CSR_TARGET_X   = 3'd0,
      CSR_TARGET_Y   = 3'd1,
      CSR_SPEED_GAIN = 3'd2,
      CSR_MAX_SPEED  = 3'd3,
      CSR_DIST_TOL   = 3'd4,
      CSR_ANGLE_TOL  = 3'd5
   } csr_index_type;

   localparam logic signed [PW-1:0] RST_TARGET_X   = PW'(1024);
   localparam logic signed [PW-1:0] RST_TARGET_Y   = PW'(1024);
   localparam logic [GW-1:0]        RST_SPEED_GAIN = GW'(256);
   localparam logic [SW-1:0]        RST_MAX_SPEED  = SW'(3072);
   localparam logic [SW-1:0]        RST_DIST_TOL   = SW'(102);
   localparam logic [SW-1:0]        RST_ANGLE_TOL  = SW'(819);

   typedef struct packed {
      logic signed [PW-1:0] target_x;
      logic signed [PW-1:0] target_y;
      logic [GW-1:0]        speed_gain;
      logic [SW-1:0]        max_speed;
      logic [SW-1:0]        distance_tolerance;
      logic [SW-1:0]        angle_tolerance;
   } cfg_type;

   // One item in flight through the CORDIC stages.
   typedef struct packed {
      logic                 valid;
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic signed [HW-1:0] heading;
   } cordic_type;

   // atan(2^-i) rounded to Q3.12.
   function automatic logic signed [ZW-1:0] atan_q12(input int i);
      logic signed [ZW-1:0] a;
      case (i)
         0:       a = ZW'(3217);
         1:       a = ZW'(1899);
         2:       a = ZW'(1003);
         3:       a = ZW'(509);
         4:       a = ZW'(256);
         5:       a = ZW'(128);
         6:       a = ZW'(64);
         7:       a = ZW'(32);
         8:       a = ZW'(16);
         9:       a = ZW'(8);
         10:      a = ZW'(4);
         11:      a = ZW'(2);
         12:      a = ZW'(1);
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

### hdl/ggsc_if.sv
// Valid/ready channel interfaces for pose items and speed command items.
// Depends on ggsc_pkg for the field widths.
interface ggsc_req_if;
   logic                          valid;
   logic                          ready;
   logic signed [ggsc_pkg::PW-1:0] pos_x;
   logic signed [ggsc_pkg::PW-1:0] pos_y;
   logic signed [ggsc_pkg::HW-1:0] heading;

   modport source (output valid, pos_x, pos_y, heading, input ready);
   modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

interface ggsc_rsp_if;
   logic                   valid;
   logic                   ready;
   logic [ggsc_pkg::SW-1:0] linear_speed;
   logic [ggsc_pkg::SW-1:0] angular_speed;

   modport source (output valid, linear_speed, angular_speed, input ready);
   modport sink   (input valid, linear_speed, angular_speed, output ready);
endinterface

### hdl/ggsc_pre.sv
// Input stage: goal offset, quadrant fold and Q5.18 scaling for the CORDIC.
// Depends on ggsc_pkg.
module ggsc_pre (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  ggsc_pkg::cfg_type               cfg,
   input  logic                            in_valid,
   input  logic signed [ggsc_pkg::PW-1:0]  pos_x,
   input  logic signed [ggsc_pkg::PW-1:0]  pos_y,
   input  logic signed [ggsc_pkg::HW-1:0]  heading,
   output ggsc_pkg::cordic_type            pre_out
);

   logic signed [ggsc_pkg::DW-1:0] dx, dy, xm, ym;
   logic signed [ggsc_pkg::ZW-1:0] z0;
   ggsc_pkg::cordic_type stage_in, stage_ff;

   always_comb begin
      dx = {cfg.target_x[ggsc_pkg::PW-1], cfg.target_x} - {pos_x[ggsc_pkg::PW-1], pos_x};
      dy = {cfg.target_y[ggsc_pkg::PW-1], cfg.target_y} - {pos_y[ggsc_pkg::PW-1], pos_y};
      // Vectors in the left half plane are turned by pi first.
      if (dx[ggsc_pkg::DW-1]) begin
         xm = -dx;
         ym = -dy;
         z0 = dy[ggsc_pkg::DW-1] ? -ggsc_pkg::PI_Q12 : ggsc_pkg::PI_Q12;
      end else begin
         xm = dx;
         ym = dy;
         z0 = '0;
      end
      stage_in.valid   = in_valid;
      stage_in.x       = {{(ggsc_pkg::XW-ggsc_pkg::DW-ggsc_pkg::PRE_SH){xm[ggsc_pkg::DW-1]}},
                          xm, {ggsc_pkg::PRE_SH{1'b0}}};
      stage_in.y       = {{(ggsc_pkg::XW-ggsc_pkg::DW-ggsc_pkg::PRE_SH){ym[ggsc_pkg::DW-1]}},
                          ym, {ggsc_pkg::PRE_SH{1'b0}}};
      stage_in.z       = z0;
      stage_in.heading = heading;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (adv) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (adv) begin
         stage_ff.x       <= stage_in.x;
         stage_ff.y       <= stage_in.y;
         stage_ff.z       <= stage_in.z;
         stage_ff.heading <= stage_in.heading;
      end
   end

   assign pre_out = stage_ff;

endmodule

### hdl/ggsc_cordic.sv
// Pipelined CORDIC vectoring unit, one micro-rotation per register stage.
// Depends on ggsc_pkg for widths, iteration count and the angle table.
module ggsc_cordic (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  ggsc_pkg::cordic_type cin,
   output ggsc_pkg::cordic_type cout
);

   localparam int N = ggsc_pkg::CORDIC_ITERATIONS;

   ggsc_pkg::cordic_type stage[0:N];

   assign stage[0] = cin;

   for (genvar i = 0; i < N; i++) begin : g_iter
      logic signed [ggsc_pkg::XW-1:0] xc, yc, xs, ys;
      ggsc_pkg::cordic_type nxt_in, nxt_ff;

      assign xc = stage[i].x;
      assign yc = stage[i].y;
      assign xs = xc >>> i;
      assign ys = yc >>> i;

      always_comb begin
         nxt_in = stage[i];
         // Rotate toward the x axis; the sign of y picks the direction.
         if (!yc[ggsc_pkg::XW-1]) begin
            nxt_in.x = xc + ys;
            nxt_in.y = yc - xs;
            nxt_in.z = stage[i].z + ggsc_pkg::atan_q12(i);
         end else begin
            nxt_in.x = xc - ys;
            nxt_in.y = yc + xs;
            nxt_in.z = stage[i].z - ggsc_pkg::atan_q12(i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            nxt_ff.valid <= 1'b0;
         end else if (adv) begin
            nxt_ff.valid <= nxt_in.valid;
         end
         if (adv) begin
            nxt_ff.x       <= nxt_in.x;
            nxt_ff.y       <= nxt_in.y;
            nxt_ff.z       <= nxt_in.z;
            nxt_ff.heading <= nxt_in.heading;
         end
      end

      assign stage[i+1] = nxt_ff;
   end

   assign cout = stage[N];

endmodule

### hdl/ggsc_post.sv
// Back end: gain correction, heading error, tolerance decisions and the
// speed command output register. Depends on ggsc_pkg.
module ggsc_post (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  ggsc_pkg::cfg_type          cfg,
   input  ggsc_pkg::cordic_type       pin,
   output logic                       out_valid,
   output logic [ggsc_pkg::SW-1:0]    linear_speed,
   output logic [ggsc_pkg::SW-1:0]    angular_speed
);

   // Stage A: distance product and absolute heading error.
   logic [ggsc_pkg::XW-2:0]        xpos;
   logic signed [ggsc_pkg::EW-1:0] err;
   logic [ggsc_pkg::EW-1:0]        err_abs_in, err_abs_ff;
   logic [ggsc_pkg::PRODW-1:0]     prod_in, prod_ff;
   logic                           a_valid_ff;

   always_comb begin
      xpos = pin.x[ggsc_pkg::XW-1] ? '0 : pin.x[ggsc_pkg::XW-2:0];
      prod_in = ggsc_pkg::PRODW'(xpos) * ggsc_pkg::PRODW'(ggsc_pkg::INV_GAIN_Q16);
      err = {pin.z[ggsc_pkg::ZW-1], pin.z}
            - {{(ggsc_pkg::EW-ggsc_pkg::HW){pin.heading[ggsc_pkg::HW-1]}}, pin.heading};
      err_abs_in = err[ggsc_pkg::EW-1] ? ggsc_pkg::EW'(-err) : ggsc_pkg::EW'(err);
   end

   // Stage B: rounded distance and the two threshold tests.
   logic [ggsc_pkg::PRODW-1:0] prod_rnd;
   logic [ggsc_pkg::DISTW-1:0] dist_in, dist_ff;
   logic                       far_ff, turn_ff, b_valid_ff;
   logic [ggsc_pkg::SW-1:0]    ang_in, ang_ff;

   always_comb begin
      prod_rnd = prod_ff + ggsc_pkg::DIST_ROUND;
      dist_in  = prod_rnd[ggsc_pkg::PRODW-1:ggsc_pkg::DIST_SHIFT];
      ang_in   = (err_abs_ff > ggsc_pkg::ANG_MAX) ? ggsc_pkg::SW'(ggsc_pkg::ANG_MAX)
                                                  : err_abs_ff[ggsc_pkg::SW-1:0];
   end

   // Stage C: gain product, speed ceiling and the result register.
   logic [ggsc_pkg::LINW-1:0]                    lin_full;
   logic [ggsc_pkg::LINW-ggsc_pkg::GAIN_SHIFT-1:0] lin_sh;
   logic [ggsc_pkg::SW-1:0]                      lin_sat, lin_in, ang_out_in;
   logic                                         out_valid_ff;
   logic [ggsc_pkg::SW-1:0]                      lin_ff, ang_out_ff;

   always_comb begin
      lin_full = ggsc_pkg::LINW'(cfg.speed_gain) * ggsc_pkg::LINW'(dist_ff);
      lin_sh   = lin_full[ggsc_pkg::LINW-1:ggsc_pkg::GAIN_SHIFT];
      lin_sat  = (lin_sh > (ggsc_pkg::LINW-ggsc_pkg::GAIN_SHIFT)'(cfg.max_speed))
                 ? cfg.max_speed : lin_sh[ggsc_pkg::SW-1:0];
      lin_in     = '0;
      ang_out_in = '0;
      if (far_ff) begin
         if (turn_ff) begin
            ang_out_in = ang_ff;
         end else begin
            lin_in = lin_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff   <= pin.valid;
         b_valid_ff   <= a_valid_ff;
         out_valid_ff <= b_valid_ff;
      end
      if (adv) begin
         prod_ff    <= prod_in;
         err_abs_ff <= err_abs_in;
         dist_ff    <= dist_in;
         far_ff     <= dist_in > ggsc_pkg::DISTW'(cfg.distance_tolerance);
         turn_ff    <= err_abs_ff > ggsc_pkg::EW'(cfg.angle_tolerance);
         ang_ff     <= ang_in;
         lin_ff     <= lin_in;
         ang_out_ff <= ang_out_in;
      end
   end

   assign out_valid     = out_valid_ff;
   assign linear_speed  = lin_ff;
   assign angular_speed = ang_out_ff;

endmodule

### hdl/go_to_goal_speed_controller.sv
// Go-to-goal speed controller: top level with configuration registers.
// Depends on ggsc_pkg, ggsc_if, ggsc_pre, ggsc_cordic and ggsc_post.
//
// Usage:
// Pose items (pos_x, pos_y, heading) arrive on req_ch; one speed command
// item (linear_speed, angular_speed) leaves on rsp_ch for each pose, in
// order. The goal, gain, speed ceiling and tolerances are written through
// csr_we / csr_index / csr_wdata while no item is in flight; writes to an
// unused index are dropped.
// The pipeline has one input stage, one stage per CORDIC micro-rotation,
// two back-end stages and the result register. Throughput is one item per
// cycle while the output does not stall; every stage is registered and no
// stage feeds back into an earlier one.
// When the receiver holds rsp_ch.ready low while a result is waiting, the
// whole pipeline freezes and req_ch.ready drops in the same cycle; nothing
// is lost or repeated, and an empty result register keeps ready high.
// Synchronous reset empties the pipeline and loads the default goal
// (1.0, 1.0), gain 1.0, ceiling 3.0, and tolerances 0.1 and 0.2.
module go_to_goal_speed_controller (
   input  logic                            clock,
   input  logic                            reset,
   ggsc_req_if.sink                        req_ch,
   ggsc_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [ggsc_pkg::CSR_IW-1:0]     csr_index,
   input  logic [ggsc_pkg::CSR_DW-1:0]     csr_wdata
);

   ggsc_pkg::cfg_type    cfg_ff;
   ggsc_pkg::cordic_type pre_out, cordic_out;
   logic                 adv;
   logic                 rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_x           <= ggsc_pkg::RST_TARGET_X;
         cfg_ff.target_y           <= ggsc_pkg::RST_TARGET_Y;
         cfg_ff.speed_gain         <= ggsc_pkg::RST_SPEED_GAIN;
         cfg_ff.max_speed          <= ggsc_pkg::RST_MAX_SPEED;
         cfg_ff.distance_tolerance <= ggsc_pkg::RST_DIST_TOL;
         cfg_ff.angle_tolerance    <= ggsc_pkg::RST_ANGLE_TOL;
      end else if (csr_we) begin
         unique case (csr_index)
            ggsc_pkg::CSR_TARGET_X:   cfg_ff.target_x   <= csr_wdata;
            ggsc_pkg::CSR_TARGET_Y:   cfg_ff.target_y   <= csr_wdata;
            ggsc_pkg::CSR_SPEED_GAIN: cfg_ff.speed_gain <= csr_wdata[ggsc_pkg::GW-1:0];
            ggsc_pkg::CSR_MAX_SPEED:  cfg_ff.max_speed  <= csr_wdata[ggsc_pkg::SW-1:0];
            ggsc_pkg::CSR_DIST_TOL: begin
               cfg_ff.distance_tolerance <= csr_wdata[ggsc_pkg::SW-1:0];
            end
            ggsc_pkg::CSR_ANGLE_TOL: begin
               cfg_ff.angle_tolerance <= csr_wdata[ggsc_pkg::SW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The pipeline moves whenever the result register is empty or drained.
   assign adv          = !rsp_valid || rsp_ch.ready;
   assign req_ch.ready = adv;

   ggsc_pre u_pre (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .cfg      (cfg_ff),
      .in_valid (req_ch.valid),
      .pos_x    (req_ch.pos_x),
      .pos_y    (req_ch.pos_y),
      .heading  (req_ch.heading),
      .pre_out  (pre_out)
   );

   ggsc_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .cin   (pre_out),
      .cout  (cordic_out)
   );

   ggsc_post u_post (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .cfg           (cfg_ff),
      .pin           (cordic_out),
      .out_valid     (rsp_valid),
      .linear_speed  (rsp_ch.linear_speed),
      .angular_speed (rsp_ch.angular_speed)
   );

   assign rsp_ch.valid = rsp_valid;

endmodule

### hdl/ggsc_checker.sv
// Port-level assertions for the go-to-goal speed controller, bound to the
// top level. Depends on ggsc_pkg for the speed width.
module ggsc_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [ggsc_pkg::SW-1:0] linear_speed,
   input logic [ggsc_pkg::SW-1:0] angular_speed
);

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds its value.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(linear_speed)
                                  && $stable(angular_speed))
      else $error("stalled result changed");

   // A command either drives or turns, never both.
   a_one_motion: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> linear_speed == '0 || angular_speed == '0)
      else $error("both speeds nonzero");

   // With no result waiting, the block takes input.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked while output empty");

   // A drained result never blocks the input.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> req_ready)
      else $error("input blocked while output drains");

endmodule

bind go_to_goal_speed_controller ggsc_checker u_ggsc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .linear_speed  (rsp_ch.linear_speed),
   .angular_speed (rsp_ch.angular_speed)
);

### sim/tb_go_to_goal_speed_controller.sv
`timescale 1ns / 100ps
// Self-checking testbench of the go-to-goal speed controller, with a local
// CORDIC-based predictor. Depends on ggsc_pkg, ggsc_if and the controller RTL.
module tb_go_to_goal_speed_controller;

   localparam logic [ggsc_pkg::CSR_IW-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [ggsc_pkg::CSR_IW-1:0] CSR_SPARE_HI = 3'd7;
   localparam int  RANDOM_PHASES   = 9;
   localparam int  POSES_PER_PHASE = 205;
   localparam int  PROBE_ROWS      = 24;
   localparam int  ATAN_LEN        = 24;
   localparam int  REPORT_LIMIT    = 10;
   localparam longint HALF_TURN_Q12 = 12868;

   localparam longint ATAN_STEP_Q12 [0:ATAN_LEN-1] = '{
      3217, 1899, 1003, 509, 256, 128, 64, 32, 16, 8, 4, 2,
      1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
   };

   typedef struct packed {
      logic signed [ggsc_pkg::PW-1:0] pos_x;
      logic signed [ggsc_pkg::PW-1:0] pos_y;
      logic signed [ggsc_pkg::HW-1:0] heading;
   } pose_type;

   typedef struct packed {
      logic [ggsc_pkg::SW-1:0] linear_speed;
      logic [ggsc_pkg::SW-1:0] angular_speed;
   } speed_cmd_type;

   typedef struct {
      int pos_x;
      int pos_y;
      int heading;
      bit typed;
      int linear_speed;
      int angular_speed;
   } probe_row_type;

   // Rows with typed results run under the reset settings: goal (1.0, 1.0),
   // gain 1.0, ceiling 3.0, stop radius 0.1, turn threshold 0.2.
   probe_row_type probe_rows [0:PROBE_ROWS-1] = '{
      '{  1024,   1024,      0, 1'b1,    0, 0},
      '{  1074,   1024,      0, 1'b1,    0, 0},
      '{  1024,   1124, -12868, 1'b1,    0, 0},
      '{-20480, -20480,   3217, 1'b1, 3072, 0},
      '{-32768,   1024,      0, 1'b1, 3072, 0},
      '{  1024,   1024,  16383, 1'b1,    0, 0},
      '{     0,   1024,      0, 1'b0,    0, 0},
      '{     0,   1024,  12868, 1'b0,    0, 0},
      '{     0,      0,  12868, 1'b0,    0, 0},
      '{     0,      0, -12868, 1'b0,    0, 0},
      '{     0,      0,  16383, 1'b0,    0, 0},
      '{     0,      0, -16384, 1'b0,    0, 0},
      '{ 32767,   1024, -16384, 1'b0,    0, 0},
      '{ 32767,  32767,      0, 1'b0,    0, 0},
      '{ 32767, -32768,      0, 1'b0,    0, 0},
      '{-32768, -32768,      0, 1'b0,    0, 0},
      '{-32768,  32767,      0, 1'b0,    0, 0},
      '{  1024, -32768,      0, 1'b0,    0, 0},
      '{  1024,  32767,      0, 1'b0,    0, 0},
      '{     0,      0,   3217, 1'b0,    0, 0},
      '{   921,   1024,      0, 1'b0,    0, 0},
      '{   922,   1024,      0, 1'b0,    0, 0},
      '{     0,   1024,    820, 1'b0,    0, 0},
      '{     0,   1024,   -819, 1'b0,    0, 0}
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [ggsc_pkg::CSR_IW-1:0] csr_index;
   logic [ggsc_pkg::CSR_DW-1:0] csr_wdata;

   ggsc_req_if req_ch ();
   ggsc_rsp_if rsp_ch ();

   go_to_goal_speed_controller u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // Local copy of the register file.
   longint goal_x, goal_y, gain_q8, speed_cap, stop_radius, turn_threshold;

   speed_cmd_type expected_cmds [$];
   int mismatches = 0;
   int poses_sent = 0;
   int cmds_checked = 0;
   int drive_cmds = 0;
   int turn_cmds = 0;
   int zero_cmds = 0;

   // CORDIC vectoring of the offset to the goal: distance in Q5.10 and
   // bearing in Q3.12, with the same floor shifts and angle steps.
   function automatic void goal_polar(input longint off_x, input longint off_y,
                                      output longint range_q10, output longint bearing);
      longint x, y, z, xs, ys;
      z = 0;
      if (off_x < 0) begin
         z = (off_y >= 0) ? HALF_TURN_Q12 : -HALF_TURN_Q12;
         off_x = -off_x;
         off_y = -off_y;
      end
      x = off_x * 256;
      y = off_y * 256;
      for (int i = 0; i < ggsc_pkg::CORDIC_ITERATIONS && i < ATAN_LEN; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ATAN_STEP_Q12[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ATAN_STEP_Q12[i];
         end
      end
      if (x < 0)
         x = 0;
      range_q10 = (x * 39797 + (64'sd1 <<< 23)) >>> 24;
      bearing = z;
   endfunction

   function automatic speed_cmd_type predict_speed_cmd(input pose_type p);
      longint range_q10, bearing, err, lin, ang;
      speed_cmd_type cmd;
      goal_polar(goal_x - longint'($signed(p.pos_x)), goal_y - longint'($signed(p.pos_y)),
                 range_q10, bearing);
      err = bearing - longint'($signed(p.heading));
      if (err < 0)
         err = -err;
      lin = 0;
      ang = 0;
      if (range_q10 > stop_radius) begin
         if (err > turn_threshold) begin
            ang = (err > 32767) ? 32767 : err;
         end else begin
            lin = (gain_q8 * range_q10) >>> 8;
            if (lin > speed_cap)
               lin = speed_cap;
         end
      end
      cmd.linear_speed = ggsc_pkg::SW'(lin);
      cmd.angular_speed = ggsc_pkg::SW'(ang);
      return cmd;
   endfunction

   function automatic longint rand_offset(input longint span);
      return longint'($urandom_range(0, 32'(2 * span))) - span;
   endfunction

   // Most poses are aimed near the goal or near the bearing so that the
   // stop and drive branches are reached, not only the turn branch.
   function automatic pose_type make_pose();
      pose_type p;
      longint range_q10, bearing, span;
      int kind;
      kind = $urandom_range(0, 9);
      p.pos_x = ggsc_pkg::PW'($urandom);
      p.pos_y = ggsc_pkg::PW'($urandom);
      p.heading = ggsc_pkg::HW'($urandom);
      case (kind)
         3, 4: begin
            span = stop_radius * 2 + 16;
            if (span > 32767)
               span = 32767;
            p.pos_x = ggsc_pkg::PW'(goal_x + rand_offset(span));
            p.pos_y = ggsc_pkg::PW'(goal_y + rand_offset(span));
            p.heading = ggsc_pkg::HW'(rand_offset(HALF_TURN_Q12));
         end
         5, 6, 7, 8: begin
            goal_polar(goal_x - longint'($signed(p.pos_x)),
                       goal_y - longint'($signed(p.pos_y)), range_q10, bearing);
            span = turn_threshold * 2 + 8;
            if (span > 16383)
               span = 16383;
            p.heading = ggsc_pkg::HW'(bearing + rand_offset(span));
         end
         9: begin
            if ($urandom_range(0, 1) == 1)
               p.heading = ggsc_pkg::HW'(16383 - longint'($urandom_range(0, 3600)));
            else
               p.heading = ggsc_pkg::HW'(-16384 + longint'($urandom_range(0, 3600)));
         end
         default: ;
      endcase
      return p;
   endfunction

   // Called just after a falling edge; returns just after a falling edge.
   task automatic send_pose(input pose_type p, input speed_cmd_type want);
      req_ch.valid = 1'b1;
      req_ch.pos_x = p.pos_x;
      req_ch.pos_y = p.pos_y;
      req_ch.heading = p.heading;
      do @(posedge clock); while (!req_ch.ready);
      expected_cmds.push_back(want);
      poses_sent++;
      if (want.linear_speed != 0)
         drive_cmds++;
      else if (want.angular_speed != 0)
         turn_cmds++;
      else
         zero_cmds++;
      @(negedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_ch.valid = 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   task automatic drain_cmds();
      req_ch.valid = 1'b0;
      while (expected_cmds.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input logic [ggsc_pkg::CSR_IW-1:0] idx,
                            input logic [ggsc_pkg::CSR_DW-1:0] data);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      case (idx)
         ggsc_pkg::CSR_TARGET_X:   goal_x = longint'($signed(data));
         ggsc_pkg::CSR_TARGET_Y:   goal_y = longint'($signed(data));
         ggsc_pkg::CSR_SPEED_GAIN: gain_q8 = longint'(data[ggsc_pkg::GW-1:0]);
         ggsc_pkg::CSR_MAX_SPEED:  speed_cap = longint'(data[ggsc_pkg::SW-1:0]);
         ggsc_pkg::CSR_DIST_TOL:   stop_radius = longint'(data[ggsc_pkg::SW-1:0]);
         ggsc_pkg::CSR_ANGLE_TOL:  turn_threshold = longint'(data[ggsc_pkg::SW-1:0]);
         default: ;
      endcase
      @(negedge clock);
   endtask

   // mode 0: every register at its low end, 1: at its high end, else random
   // with the ends mixed in.
   function automatic logic [ggsc_pkg::CSR_DW-1:0] pick_reg(
         input logic [ggsc_pkg::CSR_IW-1:0] idx, input int mode);
      bit signed_reg;
      int choice;
      signed_reg = (idx == ggsc_pkg::CSR_TARGET_X) || (idx == ggsc_pkg::CSR_TARGET_Y);
      choice = (mode < 2) ? mode : $urandom_range(0, 5);
      case (choice)
         0:       return signed_reg ? 16'h8000 : 16'h0000;
         1:       return signed_reg ? 16'h7fff
                         : ((idx == ggsc_pkg::CSR_SPEED_GAIN) ? 16'h0fff : 16'h7fff);
         default: return ggsc_pkg::CSR_DW'($urandom);
      endcase
   endfunction

   // Receiver: ready steps through a random 32-bit pattern that is redrawn periodically.
   logic [31:0] ready_pattern = '1;
   int unsigned ready_step = 0;
   always @(negedge clock) begin
      if (ready_step % 64 == 0) begin
         case ($urandom_range(0, 3))
            0:       ready_pattern = '1;
            1:       ready_pattern = $urandom | 32'd1;
            2:       ready_pattern = ($urandom & $urandom) | 32'd1;
            default: ready_pattern = $urandom | $urandom;
         endcase
      end
      rsp_ch.ready = ready_pattern[ready_step % 32];
      ready_step++;
   end

   always @(posedge clock) begin
      speed_cmd_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         cmds_checked++;
         if (expected_cmds.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected command: linear %0d angular %0d",
                        rsp_ch.linear_speed, rsp_ch.angular_speed);
         end else begin
            want = expected_cmds.pop_front();
            if (rsp_ch.linear_speed !== want.linear_speed ||
                rsp_ch.angular_speed !== want.angular_speed) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("command %0d: expected linear %0d angular %0d, got linear %0d angular %0d",
                           cmds_checked, want.linear_speed, want.angular_speed,
                           rsp_ch.linear_speed, rsp_ch.angular_speed);
            end
         end
      end
   end

   initial begin
      #8_000_000;
      $display("timeout with %0d commands outstanding", expected_cmds.size());
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      pose_type p;
      speed_cmd_type want;
      int burst_left;
      bit gaps_on;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.heading = '0;
      goal_x = 1024;
      goal_y = 1024;
      gain_q8 = 256;
      speed_cap = 3072;
      stop_radius = 102;
      turn_threshold = 819;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      foreach (probe_rows[r]) begin
         p.pos_x = ggsc_pkg::PW'(probe_rows[r].pos_x);
         p.pos_y = ggsc_pkg::PW'(probe_rows[r].pos_y);
         p.heading = ggsc_pkg::HW'(probe_rows[r].heading);
         if (probe_rows[r].typed) begin
            want.linear_speed = ggsc_pkg::SW'(probe_rows[r].linear_speed);
            want.angular_speed = ggsc_pkg::SW'(probe_rows[r].angular_speed);
         end else begin
            want = predict_speed_cmd(p);
         end
         send_pose(p, want);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         // Registers change only with nothing in flight.
         if (phase > 0) begin
            drain_cmds();
            for (int r = ggsc_pkg::CSR_TARGET_X; r <= ggsc_pkg::CSR_ANGLE_TOL; r++)
               write_reg(ggsc_pkg::CSR_IW'(r), pick_reg(ggsc_pkg::CSR_IW'(r), phase - 1));
            write_reg(($urandom_range(0, 1) == 1) ? CSR_SPARE_HI : CSR_SPARE_LO,
                      ggsc_pkg::CSR_DW'($urandom));
            csr_we = 1'b0;
         end
         gaps_on = (phase % 3 != 1);
         burst_left = 0;
         for (int n = 0; n < POSES_PER_PHASE; n++) begin
            if (burst_left == 0) begin
               pause_sender(gaps_on ? $urandom_range(0, 6) : 0);
               burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            p = make_pose();
            send_pose(p, predict_speed_cmd(p));
         end
      end

      drain_cmds();
      repeat (ggsc_pkg::CORDIC_ITERATIONS + 8) @(posedge clock);
      $display("%0d poses over %0d register settings, %0d commands checked",
               poses_sent, RANDOM_PHASES, cmds_checked);
      $display("expected commands: %0d drive, %0d turn, %0d stop; %0d mismatches",
               drive_cmds, turn_cmds, zero_cmds, mismatches);
      if (mismatches == 0 && expected_cmds.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
